FILE: rtl/number_to_word_tokens_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef NUMBER_TO_WORD_TOKENS_DEFINES_SVH
`define NUMBER_TO_WORD_TOKENS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NTW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define NTW_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ntw_pkg.sv
package ntw_pkg;

  localparam int unsigned ValueW      = 31;
  localparam int unsigned WordW       = 5;
  localparam int unsigned GroupW      = 10;
  localparam int unsigned MaxGrpWords = 5;
  localparam int unsigned NumGroups   = 4;

  typedef logic [WordW-1:0]  word_t;
  typedef logic [GroupW-1:0] group_t;

  localparam word_t WORD_ZERO      = 5'd0;
  localparam word_t WORD_TENS_BASE = 5'd18;
  localparam word_t WORD_HUNDRED   = 5'd28;
  localparam word_t WORD_THOUSAND  = 5'd29;
  localparam word_t WORD_MILLION   = 5'd30;
  localparam word_t WORD_BILLION   = 5'd31;

  // Group positions in an item, most significant first.
  localparam logic [1:0] GRP_BIL = 2'd0;
  localparam logic [1:0] GRP_MIL = 2'd1;
  localparam logic [1:0] GRP_THO = 2'd2;
  localparam logic [1:0] GRP_LOW = 2'd3;

  typedef struct packed {
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] units;
    logic [6:0] rest;
  } digits_t;

  typedef struct packed {
    word_t [MaxGrpWords-1:0] w;
    logic [2:0]              cnt;
  } grp_list_t;

  typedef grp_list_t [NumGroups-1:0] item_t;

endpackage

FILE: rtl/ntw_split.sv
module ntw_split (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_vld,
  input  logic [ntw_pkg::ValueW-1:0]  value,
  output logic                        out_vld,
  output logic [1:0]                  bil,
  output ntw_pkg::group_t             mil,
  output ntw_pkg::group_t             tho,
  output ntw_pkg::group_t             low
);

  localparam logic [30:0] Billion    = 31'd1000000000;
  localparam logic [30:0] TwoBillion = 31'd2000000000;
  localparam logic [29:0] Million    = 30'd1000000;
  localparam logic [19:0] Thousand   = 20'd1000;
  localparam logic [26:0] RecipMil   = 27'd70368745;
  localparam logic [17:0] RecipTho   = 18'd134218;

  logic [5:0]  vld_r;

  logic [30:0] v0_r;

  logic [1:0]  bil1_r, bil1_nxt;
  logic [29:0] r1_1_r, r1_1_nxt;
  logic [30:0] sub1, diff1;

  logic [1:0]  bil2_r;
  logic [29:0] r1_2_r;
  ntw_pkg::group_t mil2_r, mil2_nxt;
  logic [50:0] prod2;

  logic [1:0]  bil3_r;
  ntw_pkg::group_t mil3_r;
  logic [19:0] r2_3_r, r2_3_nxt;
  logic [29:0] prod3, diff3;

  logic [1:0]  bil4_r;
  ntw_pkg::group_t mil4_r, tho4_r, tho4_nxt;
  logic [19:0] r2_4_r;
  logic [34:0] prod4;

  logic [1:0]  bil5_r;
  ntw_pkg::group_t mil5_r, tho5_r, low5_r, low5_nxt;
  logic [19:0] prod5, diff5;

  always_comb begin
    if (v0_r >= TwoBillion) begin
      bil1_nxt = 2'd2;
      sub1     = TwoBillion;
    end else if (v0_r >= Billion) begin
      bil1_nxt = 2'd1;
      sub1     = Billion;
    end else begin
      bil1_nxt = 2'd0;
      sub1     = '0;
    end
    diff1    = v0_r - sub1;
    r1_1_nxt = diff1[29:0];
  end

  always_comb begin
    prod2    = 51'(r1_1_r[29:6]) * 51'(RecipMil);
    mil2_nxt = prod2[49:40];
  end

  always_comb begin
    prod3    = 30'(mil2_r) * Million;
    diff3    = r1_2_r - prod3;
    r2_3_nxt = diff3[19:0];
  end

  always_comb begin
    prod4    = 35'(r2_3_r[19:3]) * 35'(RecipTho);
    tho4_nxt = prod4[33:24];
  end

  always_comb begin
    prod5    = 20'(tho4_r) * Thousand;
    diff5    = r2_4_r - prod5;
    low5_nxt = diff5[9:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v0_r   <= value;
      bil1_r <= bil1_nxt;
      r1_1_r <= r1_1_nxt;
      bil2_r <= bil1_r;
      r1_2_r <= r1_1_r;
      mil2_r <= mil2_nxt;
      bil3_r <= bil2_r;
      mil3_r <= mil2_r;
      r2_3_r <= r2_3_nxt;
      bil4_r <= bil3_r;
      mil4_r <= mil3_r;
      r2_4_r <= r2_3_r;
      tho4_r <= tho4_nxt;
      bil5_r <= bil4_r;
      mil5_r <= mil4_r;
      tho5_r <= tho4_r;
      low5_r <= low5_nxt;
    end
  end

  assign out_vld = vld_r[5];
  assign bil     = bil5_r;
  assign mil     = mil5_r;
  assign tho     = tho5_r;
  assign low     = low5_r;

endmodule

FILE: rtl/ntw_digits.sv
module ntw_digits (
  input  logic             clk,
  input  logic             adv,
  input  ntw_pkg::group_t  grp,
  output ntw_pkg::digits_t digits
);

  ntw_pkg::group_t  grp_r;
  logic [3:0]       hund_r, hund_nxt;
  logic [6:0]       d10_r, d10_nxt;
  logic [15:0]      prod_h;
  logic [17:0]      prod_d;
  logic [9:0]       rest_full, units_full;
  logic [6:0]       tens_full;
  ntw_pkg::digits_t digits_r, digits_nxt;

  // Hundreds and tens by reciprocal multiplication, exact for values below 1000.
  always_comb begin
    prod_h   = 16'(grp) * 16'd41;
    prod_d   = 18'(grp) * 18'd205;
    hund_nxt = prod_h[15:12];
    d10_nxt  = prod_d[17:11];
  end

  always_comb begin
    rest_full        = grp_r - 10'(hund_r) * 10'd100;
    tens_full        = d10_r - 7'(hund_r) * 7'd10;
    units_full       = grp_r - 10'(d10_r) * 10'd10;
    digits_nxt.hund  = hund_r;
    digits_nxt.tens  = tens_full[3:0];
    digits_nxt.units = units_full[3:0];
    digits_nxt.rest  = rest_full[6:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grp_r    <= grp;
      hund_r   <= hund_nxt;
      d10_r    <= d10_nxt;
      digits_r <= digits_nxt;
    end
  end

  assign digits = digits_r;

endmodule

FILE: rtl/ntw_words.sv
module ntw_words (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_vld,
  input  logic [1:0]       bil,
  input  ntw_pkg::digits_t mil,
  input  ntw_pkg::digits_t tho,
  input  ntw_pkg::digits_t low,
  output logic             out_vld,
  output ntw_pkg::item_t   item
);

  logic             vld_r;
  ntw_pkg::item_t   item_r, item_nxt;
  ntw_pkg::digits_t bil_digits;
  logic             all_zero;

  function automatic ntw_pkg::grp_list_t build_list(ntw_pkg::digits_t d,
                                                    ntw_pkg::word_t scale,
                                                    logic has_scale);
    ntw_pkg::grp_list_t l;
    logic [2:0]         n;
    l = '0;
    n = 3'd0;
    if (d.hund != 4'd0) begin
      l.w[n] = ntw_pkg::word_t'(d.hund);
      n      = n + 3'd1;
      l.w[n] = ntw_pkg::WORD_HUNDRED;
      n      = n + 3'd1;
    end
    if (d.rest != 7'd0) begin
      if (d.rest < 7'd20) begin
        l.w[n] = ntw_pkg::word_t'(d.rest);
        n      = n + 3'd1;
      end else begin
        l.w[n] = ntw_pkg::WORD_TENS_BASE + ntw_pkg::word_t'(d.tens);
        n      = n + 3'd1;
        if (d.units != 4'd0) begin
          l.w[n] = ntw_pkg::word_t'(d.units);
          n      = n + 3'd1;
        end
      end
    end
    if (has_scale && (d.hund != 4'd0 || d.rest != 7'd0)) begin
      l.w[n] = scale;
      n      = n + 3'd1;
    end
    l.cnt = n;
    return l;
  endfunction

  always_comb begin
    bil_digits.hund  = 4'd0;
    bil_digits.tens  = 4'd0;
    bil_digits.units = 4'(bil);
    bil_digits.rest  = 7'(bil);
    all_zero = (bil == 2'd0) &&
               (mil.hund == 4'd0) && (mil.rest == 7'd0) &&
               (tho.hund == 4'd0) && (tho.rest == 7'd0) &&
               (low.hund == 4'd0) && (low.rest == 7'd0);
    item_nxt[ntw_pkg::GRP_BIL] = build_list(bil_digits, ntw_pkg::WORD_BILLION, 1'b1);
    item_nxt[ntw_pkg::GRP_MIL] = build_list(mil, ntw_pkg::WORD_MILLION, 1'b1);
    item_nxt[ntw_pkg::GRP_THO] = build_list(tho, ntw_pkg::WORD_THOUSAND, 1'b1);
    item_nxt[ntw_pkg::GRP_LOW] = build_list(low, ntw_pkg::WORD_ZERO, 1'b0);
    if (all_zero) begin
      item_nxt[ntw_pkg::GRP_LOW].w[0] = ntw_pkg::WORD_ZERO;
      item_nxt[ntw_pkg::GRP_LOW].cnt  = 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign out_vld = vld_r;
  assign item    = item_r;

endmodule

FILE: rtl/ntw_serializer.sv
module ntw_serializer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_vld,
  input  ntw_pkg::item_t item,
  output logic           item_take,
  output logic           out_valid,
  input  logic           out_ready,
  output ntw_pkg::word_t out_word_code,
  output logic           out_last_word
);

  logic                           started_r, started_nxt;
  logic [1:0]                     grp_r, grp_nxt;
  logic [2:0]                     slot_r, slot_nxt;
  logic                           out_valid_r;
  ntw_pkg::word_t                 word_r;
  logic                           last_r;
  logic [ntw_pkg::NumGroups-1:0]  nonempty;
  logic [1:0]                     first_grp, cur_grp, nxt_grp;
  logic [2:0]                     cur_slot, slot_inc;
  logic                           has_nxt, grp_end, is_last, emit;
  ntw_pkg::word_t                 cur_word;

  always_comb begin
    first_grp = ntw_pkg::GRP_LOW;
    for (int k = ntw_pkg::NumGroups - 1; k >= 0; k--) begin
      nonempty[k] = (item[k].cnt != 3'd0);
      if (nonempty[k]) begin
        first_grp = 2'(k);
      end
    end
  end

  always_comb begin
    cur_grp  = started_r ? grp_r : first_grp;
    cur_slot = started_r ? slot_r : 3'd0;
    has_nxt  = 1'b0;
    nxt_grp  = cur_grp;
    for (int k = ntw_pkg::NumGroups - 1; k >= 0; k--) begin
      if (2'(k) > cur_grp && nonempty[k]) begin
        has_nxt = 1'b1;
        nxt_grp = 2'(k);
      end
    end
    slot_inc  = cur_slot + 3'd1;
    grp_end   = (slot_inc == item[cur_grp].cnt);
    is_last   = grp_end && !has_nxt;
    cur_word  = item[cur_grp].w[cur_slot];
    emit      = item_vld && (!out_valid_r || out_ready);
    item_take = emit && is_last;
  end

  always_comb begin
    started_nxt = started_r;
    grp_nxt     = grp_r;
    slot_nxt    = slot_r;
    if (emit) begin
      if (is_last) begin
        started_nxt = 1'b0;
        grp_nxt     = ntw_pkg::GRP_BIL;
        slot_nxt    = 3'd0;
      end else if (grp_end) begin
        started_nxt = 1'b1;
        grp_nxt     = nxt_grp;
        slot_nxt    = 3'd0;
      end else begin
        started_nxt = 1'b1;
        grp_nxt     = cur_grp;
        slot_nxt    = slot_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      grp_r       <= ntw_pkg::GRP_BIL;
      slot_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      started_r <= started_nxt;
      grp_r     <= grp_nxt;
      slot_r    <= slot_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      word_r <= cur_word;
      last_r <= is_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_word_code = word_r;
  assign out_last_word = last_r;

endmodule

FILE: rtl/number_to_word_tokens.sv
// Names a 31-bit unsigned value as a run of English word codes, one per output word.
// Input channel: in_valid/in_ready with in_value. A value is taken at a rising edge
// where both are high. Output channel: out_valid/out_ready with out_word_code and
// out_last_word, which is set on the final word of each value's run.
// A value is split into billions, millions, thousands and a low group by a
// pipeline of compares and constant-reciprocal multiplies, then each group into
// digits, then into a word list. The input side is a nine-stage pipeline.
// The output side sends one word per cycle while out_ready stays high; a value has
// from 1 to 16 words, and the next value enters while earlier ones are in flight.
// When out_ready is low the output word holds. The pipeline moves as a whole; it and
// in_ready stall while the word list stage holds a value whose last word is not sent.
// Synchronous active-low reset empties every stage and drops out_valid; no
// memory needs a clearing pass.
module number_to_word_tokens (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ntw_pkg::ValueW-1:0]  in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ntw_pkg::WordW-1:0]   out_word_code,
  output logic                        out_last_word
);

  logic             adv;
  logic             split_vld, words_vld, item_take;
  logic             vld6_r, vld7_r;
  logic [1:0]       bil5, bil6_r, bil7_r;
  ntw_pkg::group_t  mil5, tho5, low5;
  ntw_pkg::digits_t mil_dig, tho_dig, low_dig;
  ntw_pkg::item_t   item;

  assign adv      = !words_vld || item_take;
  assign in_ready = adv;

  ntw_split u_split (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid),
    .value   (in_value),
    .out_vld (split_vld),
    .bil     (bil5),
    .mil     (mil5),
    .tho     (tho5),
    .low     (low5)
  );

  ntw_digits u_digits_mil (
    .clk    (clk),
    .adv    (adv),
    .grp    (mil5),
    .digits (mil_dig)
  );

  ntw_digits u_digits_tho (
    .clk    (clk),
    .adv    (adv),
    .grp    (tho5),
    .digits (tho_dig)
  );

  ntw_digits u_digits_low (
    .clk    (clk),
    .adv    (adv),
    .grp    (low5),
    .digits (low_dig)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
    end else if (adv) begin
      vld6_r <= split_vld;
      vld7_r <= vld6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bil6_r <= bil5;
      bil7_r <= bil6_r;
    end
  end

  ntw_words u_words (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (vld7_r),
    .bil     (bil7_r),
    .mil     (mil_dig),
    .tho     (tho_dig),
    .low     (low_dig),
    .out_vld (words_vld),
    .item    (item)
  );

  ntw_serializer u_serializer (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_vld      (words_vld),
    .item          (item),
    .item_take     (item_take),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_word_code (out_word_code),
    .out_last_word (out_last_word)
  );

endmodule

FILE: rtl/ntw_checker.sv
`include "number_to_word_tokens_defines.svh"

module ntw_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [ntw_pkg::ValueW-1:0]  in_value,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ntw_pkg::WordW-1:0]   out_word_code,
  input logic                        out_last_word
);

  logic in_seen;

  assign in_seen = in_valid && in_ready && (in_value == '0);

  `NTW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "output word dropped while stalled")
  `NTW_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_word_code) && $stable(out_last_word), "output word changed while stalled")
  `NTW_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid, "output valid after reset")
  `NTW_ASSERT_NOW(a_zero_alone, clk, rst_n, out_valid && out_word_code == ntw_pkg::WORD_ZERO, out_last_word, "word Zero is not the last word")
  `NTW_ASSERT_NEXT(a_zero_take, clk, rst_n, in_seen, !out_valid || out_last_word || out_word_code != ntw_pkg::WORD_ZERO, "word Zero without last flag")

endmodule

bind number_to_word_tokens ntw_checker u_ntw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_value      (in_value),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_word_code (out_word_code),
  .out_last_word (out_last_word)
);

FILE: verif/tb_number_to_word_tokens.sv
module tb_number_to_word_tokens;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned VALUE_W = ntw_pkg::ValueW;
  localparam longint unsigned VALUE_MAX = 64'd2147483647;

  typedef enum logic [4:0] {
    W_ZERO, W_ONE, W_TWO, W_THREE, W_FOUR, W_FIVE, W_SIX, W_SEVEN, W_EIGHT, W_NINE,
    W_TEN, W_ELEVEN, W_TWELVE, W_THIRTEEN, W_FOURTEEN, W_FIFTEEN, W_SIXTEEN,
    W_SEVENTEEN, W_EIGHTEEN, W_NINETEEN, W_TWENTY, W_THIRTY, W_FORTY, W_FIFTY,
    W_SIXTY, W_SEVENTY, W_EIGHTY, W_NINETY, W_HUNDRED, W_THOUSAND, W_MILLION,
    W_BILLION
  } word_name_e;

  typedef struct packed {
    ntw_pkg::word_t code;
    logic           last;
  } token_t;

  typedef token_t token_q_t [$];

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    int unsigned        nwords;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [VALUE_W-1:0] in_value;
  logic               out_valid;
  logic               out_ready;
  ntw_pkg::word_t     out_word_code;
  logic               out_last_word;

  token_q_t    staged_words;
  token_q_t    expected_words;
  int unsigned errors;
  int unsigned values_taken;
  int unsigned words_seen;
  int unsigned quiet_cycles;
  bit          src_gaps;
  bit          stall_enable;
  bit          hold_request;

  // Rows with a nonzero count take their expected words, in order, from typed_words.
  row_t dir_rows [25] = '{
    '{31'd0, 1}, '{31'd1, 1}, '{31'd19, 1}, '{31'd20, 1}, '{31'd21, 0},
    '{31'd99, 0}, '{31'd100, 2}, '{31'd110, 0}, '{31'd115, 0}, '{31'd999, 0},
    '{31'd1000, 2}, '{31'd1001, 0}, '{31'd12345, 0}, '{31'd90000, 0},
    '{31'd1000000, 2}, '{31'd1010010, 0}, '{31'd500000000, 0},
    '{31'd1000000000, 2}, '{31'd1000001000, 0}, '{31'd1073741824, 0},
    '{31'd1777777777, 0}, '{31'd1999999999, 0}, '{31'd2000000000, 0},
    '{31'd2000000001, 0}, '{31'd2147483647, 16}
  };

  word_name_e typed_words [28] = '{
    W_ZERO, W_ONE, W_NINETEEN, W_TWENTY,
    W_ONE, W_HUNDRED, W_ONE, W_THOUSAND, W_ONE, W_MILLION, W_ONE, W_BILLION,
    W_TWO, W_BILLION, W_ONE, W_HUNDRED, W_FORTY, W_SEVEN, W_MILLION,
    W_FOUR, W_HUNDRED, W_EIGHTY, W_THREE, W_THOUSAND, W_SIX, W_HUNDRED, W_FORTY, W_SEVEN
  };

  number_to_word_tokens dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word_code(out_word_code),
    .out_last_word(out_last_word)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic token_q_t spell_value(input logic [VALUE_W-1:0] v);
    token_q_t       words;
    int unsigned    grp [4];
    ntw_pkg::word_t scale [3];
    int unsigned    hund;
    int unsigned    rest;
    grp[0] = v / 1000000000;
    grp[1] = (v / 1000000) % 1000;
    grp[2] = (v / 1000) % 1000;
    grp[3] = v % 1000;
    scale = '{ntw_pkg::WORD_BILLION, ntw_pkg::WORD_MILLION, ntw_pkg::WORD_THOUSAND};
    if (v == '0) begin
      words.push_back(token_t'{ntw_pkg::WORD_ZERO, 1'b0});
    end else begin
      for (int g = 0; g < 4; g++) begin
        if (grp[g] != 0) begin
          hund = grp[g] / 100;
          rest = grp[g] % 100;
          if (hund != 0) begin
            words.push_back(token_t'{ntw_pkg::word_t'(hund), 1'b0});
            words.push_back(token_t'{ntw_pkg::WORD_HUNDRED, 1'b0});
          end
          if (rest != 0 && rest < 20) begin
            words.push_back(token_t'{ntw_pkg::word_t'(rest), 1'b0});
          end else if (rest != 0) begin
            words.push_back(token_t'{ntw_pkg::WORD_TENS_BASE + ntw_pkg::word_t'(rest / 10),
                                     1'b0});
            if (rest % 10 != 0) words.push_back(token_t'{ntw_pkg::word_t'(rest % 10), 1'b0});
          end
          if (g < 3) words.push_back(token_t'{scale[g], 1'b0});
        end
      end
    end
    words[words.size()-1].last = 1'b1;
    return words;
  endfunction

  task automatic offer_value(input logic [VALUE_W-1:0] v, input token_q_t words);
    @(negedge clk);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    staged_words = words;
    in_value <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic sender_pause();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  task automatic random_values(input int unsigned count);
    logic [VALUE_W-1:0] v;
    longint unsigned    grp_sum;
    longint unsigned    p;
    int unsigned        part;
    int unsigned        cls;
    repeat (count) begin
      cls = $urandom_range(0, 9);
      case (cls) inside
        [0:3]: v = VALUE_W'($urandom());
        4: v = VALUE_W'($urandom_range(0, 999));
        5: v = VALUE_W'($urandom_range(0, 99));
        [6:7]: begin
          grp_sum = 0;
          for (int g = 0; g < 4; g++) begin
            if (cls == 7) begin
              part = (g == 0) ? 1 : 100 * $urandom_range(1, 9) + 10 * $urandom_range(2, 9)
                                    + $urandom_range(1, 9);
            end else begin
              part = $urandom_range(0, 1) ? 0 : $urandom_range(0, (g == 0) ? 2 : 999);
            end
            grp_sum = grp_sum * 1000 + part;
          end
          if (grp_sum > VALUE_MAX) grp_sum -= 1000000000;
          v = grp_sum[VALUE_W-1:0];
        end
        8: begin
          p = 1;
          repeat ($urandom_range(0, 9)) p = p * 10;
          grp_sum = p * $urandom_range(1, 9);
          if (grp_sum > VALUE_MAX) grp_sum = p;
          v = grp_sum[VALUE_W-1:0];
        end
        default: v = VALUE_W'(VALUE_MAX - $urandom_range(0, 1000));
      endcase
      offer_value(v, spell_value(v));
    end
  endtask

  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (stall_enable && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    token_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        foreach (staged_words[i]) expected_words.push_back(staged_words[i]);
        values_taken++;
      end
      if (out_valid && out_ready) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          $display("%0t: word with nothing expected: code %0d last %0b",
                   $time, out_word_code, out_last_word);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (out_word_code !== want.code) begin
            $display("%0t: word_code mismatch: expected %0d, actual %0d",
                     $time, want.code, out_word_code);
            errors++;
          end
          if (out_last_word !== want.last) begin
            $display("%0t: last_word mismatch: expected %0b, actual %0b",
                     $time, want.last, out_last_word);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: timeout, %0d words still expected", $time, expected_words.size());
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  initial begin
    token_q_t    words;
    int unsigned ptr;
    in_valid = 1'b0;
    in_value = '0;
    src_gaps = 1'b1;
    stall_enable = 1'b1;
    hold_request = 1'b0;
    errors = 0;
    values_taken = 0;
    words_seen = 0;
    quiet_cycles = 0;
    ptr = 0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].nwords == 0) begin
        words = spell_value(dir_rows[r].value);
      end else begin
        words = {};
        for (int k = 0; k < dir_rows[r].nwords; k++) begin
          words.push_back(token_t'{ntw_pkg::word_t'(typed_words[ptr + k]),
                                   k == dir_rows[r].nwords - 1});
        end
        ptr += dir_rows[r].nwords;
      end
      offer_value(dir_rows[r].value, words);
    end

    random_values(150);
    sender_pause();

    // The output side holds off while values keep coming, so the input backs up.
    src_gaps = 1'b0;
    @(posedge clk);
    hold_request = 1'b1;
    random_values(40);
    src_gaps = 1'b1;
    sender_pause();

    random_values(140);
    src_gaps = 1'b0;
    stall_enable = 1'b0;
    random_values(55);
    sender_pause();
    repeat (40) @(negedge clk);

    $display("Checked %0d words from %0d values: zero, teens, tens, empty groups,",
             words_seen, values_taken);
    $display("sixteen-word values, a long output hold-off and a back-to-back tail.");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ntw_pkg.sv
rtl/ntw_split.sv
rtl/ntw_digits.sv
rtl/ntw_words.sv
rtl/ntw_serializer.sv
rtl/number_to_word_tokens.sv
rtl/ntw_checker.sv
verif/tb_number_to_word_tokens.sv
